FILE: src/pce_pkg.sv
// package for the piecewise curve envelope: payload structs, codes, constants
// used by all modules in src
package pce_pkg;

    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int Q16_ONE          = 65536;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_TOTAL_LENGTH  = 2'd0,
        CFG_START_LEVEL   = 2'd1,
        CFG_SEGMENT_COUNT = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot;
        logic [16:0] seg_fraction;
        logic [16:0] seg_target;
        logic        seg_shape;
        logic [23:0] shape_a;
    } in_item_t;

    typedef struct packed {
        logic [16:0] level;
        logic [3:0]  segment_now;
        logic        finished;
        logic        overrun_error;
        logic        domain_clamp;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SKIP,
        ST_X_DIV,
        ST_CUBE1,
        ST_CUBE2,
        ST_CIS_DIV,
        ST_CIS_CHK,
        ST_CIS_DIV2,
        ST_CIS_SUM,
        ST_SQRT,
        ST_SCALE,
        ST_EMIT
    } state_t;

    function automatic logic [16:0] sat17(input logic [16:0] v);
        return (v > 17'(Q16_ONE)) ? 17'(Q16_ONE) : v;
    endfunction

endpackage

FILE: src/pce_front.sv
// front part: queues incoming items in arrival order and hands them to the
// back part, which classifies and carries them out; uses pce_pkg
module pce_front #(
    parameter int QDEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pce_pkg::in_item_t in_item,
    output logic              cmd_valid,
    output pce_pkg::in_item_t cmd_item,
    input  logic              cmd_take
);
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    pce_pkg::in_item_t  q_mem [QDEPTH];
    logic [PW-1:0]      wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]        cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == (PW+1)'(QDEPTH));
    assign do_push  = push && !full;
    assign do_pop   = cmd_take && (cnt_reg != '0);
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_item = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == PW'(QDEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == PW'(QDEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_reg] <= in_item;
    end
endmodule

FILE: src/pce_back.sv
// back part: segment table, curve position state and the iterative
// divide / square root engine that computes one level per tick; uses pce_pkg
module pce_back #(
    parameter int MAX_SEGMENTS = pce_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = pce_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  pce_pkg::in_item_t  cmd_item,
    output logic               cmd_take,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               res_valid,
    output pce_pkg::out_item_t res_item,
    input  logic               res_take
);
    localparam int SW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int XW   = FRAC_BITS + 1;
    localparam int DW   = FRAC_BITS + 10;      // 2a - x width
    localparam int PW   = 2 * FRAC_BITS + 10;  // holds r1 * x below 2a * x
    localparam int SUMW = 17 + CW;
    localparam logic [PW-1:0] LIM = PW'(1) << (2 * FRAC_BITS);
    localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;

    // tables (written on loads, kept in flops with reset clear)
    logic [16:0] frac_reg  [MAX_SEGMENTS];
    logic [16:0] tgt_reg   [MAX_SEGMENTS];
    logic        shp_reg   [MAX_SEGMENTS];
    logic [23:0] par_reg   [MAX_SEGMENTS];

    logic [16:0] total_len_reg, start_lvl_reg;
    logic [CW-1:0] seg_cnt_reg;

    logic [CW-1:0] seg_idx_reg, seg_idx_next;
    logic [16:0]   pos_seg_reg, pos_seg_next;
    logic [16:0]   tot_pos_reg, tot_pos_next;
    logic [16:0]   from_reg, from_next;

    pce_pkg::state_t st_reg, st_next;

    logic [SUMW-1:0] sum_reg, sum_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [16:0]     len_reg, len_next;
    logic [PW-1:0]   num_reg, num_next;   // dividend / remainder shift
    logic [PW-1:0]   quo_reg, quo_next;
    logic [PW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [6:0]      it_reg, it_next;
    logic [XW-1:0]   xq_reg, xq_next;
    logic [PW-1:0]   acc_reg, acc_next;   // q1 then q, sqrt operand
    logic [PW-1:0]   sq_res_reg, sq_res_next;
    logic [PW-1:0]   sq_bit_reg, sq_bit_next;
    logic [XW-1:0]   s_reg, s_next;
    logic            clamp_reg, clamp_next;
    logic            res_v_reg, res_v_next;
    pce_pkg::out_item_t res_reg, res_next;

    logic [SW-1:0]    sidx;
    logic             in_range;
    logic [33:0]      len_prod;
    logic [16:0]      cur_len;
    logic [PW-1:0]    rem_try;
    logic [XW+PW-1:0] mul_out;
    logic [DW-1:0]    twoa;
    logic [16:0]      low, span;
    logic             falling;
    logic [XW-1:0]    s_dir;
    logic [XW+16:0]   scaled;
    logic             ld;
    logic [SW-1:0]    ld_slot;

    assign sidx     = seg_idx_reg[SW-1:0];
    assign in_range = (seg_idx_reg < seg_cnt_reg);
    assign len_prod = 34'(frac_reg[sidx]) * 34'(total_len_reg);
    assign cur_len  = len_prod[32:16];
    // a is Q8.16, rescaled to the x format before doubling
    assign twoa     = DW'((DW+16)'(par_reg[sidx]) << FRAC_BITS >> 16) << 1;
    assign falling  = (from_reg > tgt_reg[sidx]);
    assign low      = falling ? tgt_reg[sidx] : from_reg;
    assign span     = falling ? (from_reg - tgt_reg[sidx]) : (tgt_reg[sidx] - from_reg);
    assign s_dir    = falling ? (ONE - s_reg) : s_reg;
    assign scaled   = (XW+17)'(s_dir) * (XW+17)'(span);
    assign mul_out  = (XW+PW)'(xq_reg) * (XW+PW)'(acc_reg);
    assign ld       = cmd_valid && (st_reg == pce_pkg::ST_IDLE)
                      && (cmd_item.action == pce_pkg::ACT_LOAD)
                      && (32'(cmd_item.slot) < 32'(MAX_SEGMENTS));
    assign ld_slot  = SW'(cmd_item.slot);

    assign res_valid = res_v_reg;
    assign res_item  = res_reg;

    always_comb
    begin
        st_next      = st_reg;
        seg_idx_next = seg_idx_reg;
        pos_seg_next = pos_seg_reg;
        tot_pos_next = tot_pos_reg;
        from_next    = from_reg;
        sum_next     = sum_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        it_next      = it_reg;
        xq_next      = xq_reg;
        acc_next     = acc_reg;
        sq_res_next  = sq_res_reg;
        sq_bit_next  = sq_bit_reg;
        s_next       = s_reg;
        clamp_next   = clamp_reg;
        res_v_next   = res_v_reg && !res_take;
        res_next     = res_reg;
        cmd_take     = 1'b0;
        rem_try      = {rem_reg[PW-2:0], num_reg[PW-1]} - PW'(den_reg);

        unique case (st_reg)
            pce_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_item.action)
                        pce_pkg::ACT_LOAD:
                            cmd_take = 1'b1;
                        pce_pkg::ACT_RESTART:
                        begin
                            cmd_take     = 1'b1;
                            seg_idx_next = '0;
                            pos_seg_next = '0;
                            tot_pos_next = '0;
                            from_next    = start_lvl_reg;
                        end
                        pce_pkg::ACT_TICK:
                        begin
                            if (!res_v_reg || res_take)
                            begin
                                cmd_take = 1'b1;
                                sum_next = '0;
                                k_next   = '0;
                                st_next  = pce_pkg::ST_SUM;
                            end
                        end
                        default:
                            cmd_take = 1'b1;
                    endcase
                end
            end
            pce_pkg::ST_SUM:
            begin
                if (k_reg < seg_cnt_reg)
                begin
                    sum_next = sum_reg + SUMW'(frac_reg[k_reg[SW-1:0]]);
                    k_next   = k_reg + 1'b1;
                end
                else
                begin
                    res_next.level         = '0;
                    res_next.segment_now   = 4'(MAX_SEGMENTS);
                    res_next.domain_clamp  = 1'b0;
                    res_next.overrun_error = 1'b0;
                    res_next.finished      = (tot_pos_reg >= total_len_reg);
                    if (sum_reg > SUMW'(pce_pkg::Q16_ONE))
                    begin
                        res_next.overrun_error = 1'b1;
                        st_next = pce_pkg::ST_EMIT;
                    end
                    else if (tot_pos_reg >= total_len_reg)
                        st_next = pce_pkg::ST_EMIT;
                    else
                        st_next = pce_pkg::ST_SKIP;
                end
            end
            pce_pkg::ST_SKIP:
            begin
                if (in_range && pos_seg_reg >= cur_len)
                begin
                    from_next    = tgt_reg[sidx];
                    seg_idx_next = seg_idx_reg + 1'b1;
                    pos_seg_next = '0;
                end
                else if (in_range)
                begin
                    // x = pos * ONE / len
                    len_next = cur_len;
                    num_next = PW'({pos_seg_reg, {FRAC_BITS{1'b0}}}) << (PW - 17 - FRAC_BITS);
                    den_next = DW'(cur_len);
                    rem_next = '0;
                    quo_next = '0;
                    it_next  = 7'(17 + FRAC_BITS);
                    clamp_next = 1'b0;
                    st_next  = pce_pkg::ST_X_DIV;
                end
                else
                begin
                    tot_pos_next = tot_pos_reg + 1'b1;
                    res_next.finished = ((tot_pos_reg + 1'b1) >= total_len_reg);
                    st_next = pce_pkg::ST_EMIT;
                end
            end
            pce_pkg::ST_X_DIV, pce_pkg::ST_CIS_DIV, pce_pkg::ST_CIS_DIV2:
            begin
                // restoring divider, one quotient bit per cycle
                num_next = num_reg << 1;
                if (!rem_try[PW-1] && ({rem_reg[PW-2:0], num_reg[PW-1]} >= PW'(den_reg)))
                begin
                    rem_next = rem_try;
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[PW-2:0], num_reg[PW-1]};
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                it_next = it_reg - 1'b1;
                if (it_reg == 7'd1)
                begin
                    if (st_reg == pce_pkg::ST_X_DIV)
                    begin
                        xq_next = XW'(quo_next);
                        if (shp_reg[sidx])
                        begin
                            acc_next = PW'(XW'(quo_next));
                            st_next  = pce_pkg::ST_CUBE1;
                        end
                        else if (twoa <= DW'(XW'(quo_next)))
                        begin
                            clamp_next = 1'b1;
                            s_next     = ONE;
                            st_next    = pce_pkg::ST_SCALE;
                        end
                        else
                        begin
                            acc_next = '0;
                            den_next = twoa - DW'(XW'(quo_next));
                            num_next = PW'(XW'(quo_next)) * PW'(XW'(quo_next));
                            rem_next = '0;
                            quo_next = '0;
                            it_next  = 7'(PW);
                            st_next  = pce_pkg::ST_CIS_DIV;
                        end
                    end
                    else if (st_reg == pce_pkg::ST_CIS_DIV)
                    begin
                        acc_next = quo_next;       // q1
                        sum_next = '0;
                        st_next  = pce_pkg::ST_CIS_CHK;
                    end
                    else
                    begin
                        acc_next = acc_reg + quo_next;
                        st_next  = pce_pkg::ST_CIS_SUM;
                    end
                end
            end
            pce_pkg::ST_CUBE1:
            begin
                acc_next = PW'(mul_out >> FRAC_BITS);
                st_next  = pce_pkg::ST_CUBE2;
            end
            pce_pkg::ST_CUBE2:
            begin
                s_next  = XW'(mul_out >> FRAC_BITS);
                st_next = pce_pkg::ST_SCALE;
            end
            pce_pkg::ST_CIS_CHK:
            begin
                // q1*x and then (r1*x)/d
                if (xq_reg != '0 && mul_out > (XW+PW)'(LIM))
                begin
                    clamp_next = 1'b1;
                    s_next     = ONE;
                    st_next    = pce_pkg::ST_SCALE;
                end
                else
                begin
                    acc_next = PW'(mul_out);
                    num_next = PW'(xq_reg) * rem_reg;
                    rem_next = '0;
                    quo_next = '0;
                    it_next  = 7'(PW);
                    st_next  = pce_pkg::ST_CIS_DIV2;
                end
            end
            pce_pkg::ST_CIS_SUM:
            begin
                if (acc_reg > LIM)
                begin
                    clamp_next = 1'b1;
                    s_next     = ONE;
                    st_next    = pce_pkg::ST_SCALE;
                end
                else
                begin
                    sq_res_next = '0;
                    sq_bit_next = LIM;
                    st_next     = pce_pkg::ST_SQRT;
                end
            end
            pce_pkg::ST_SQRT:
            begin
                // digit-by-digit root, one result bit per cycle
                if (sq_bit_reg == '0)
                begin
                    s_next  = XW'(sq_res_reg);
                    st_next = pce_pkg::ST_SCALE;
                end
                else
                begin
                    if (acc_reg >= sq_res_reg + sq_bit_reg)
                    begin
                        acc_next    = acc_reg - (sq_res_reg + sq_bit_reg);
                        sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_next = sq_res_reg >> 1;
                    sq_bit_next = sq_bit_reg >> 2;
                end
            end
            pce_pkg::ST_SCALE:
            begin
                res_next.level         = low + 17'(scaled >> FRAC_BITS);
                res_next.segment_now   = 4'(seg_idx_reg);
                res_next.domain_clamp  = clamp_reg;
                res_next.overrun_error = 1'b0;
                res_next.finished      = ((tot_pos_reg + 1'b1) >= total_len_reg);
                tot_pos_next = tot_pos_reg + 1'b1;
                if ((pos_seg_reg + 1'b1) >= len_reg)
                begin
                    from_next    = tgt_reg[sidx];
                    seg_idx_next = seg_idx_reg + 1'b1;
                    pos_seg_next = '0;
                end
                else
                    pos_seg_next = pos_seg_reg + 1'b1;
                st_next = pce_pkg::ST_EMIT;
            end
            pce_pkg::ST_EMIT:
            begin
                res_v_next = 1'b1;
                st_next    = pce_pkg::ST_IDLE;
            end
            default:
                st_next = pce_pkg::ST_IDLE;
        endcase

        if (cfg_write && cfg_index != pce_pkg::CFG_UNUSED)
        begin
            seg_idx_next = '0;
            pos_seg_next = '0;
            tot_pos_next = '0;
            unique case (cfg_index)
                pce_pkg::CFG_START_LEVEL:
                    from_next = pce_pkg::sat17(cfg_data[16:0]);
                default:
                    from_next = start_lvl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= pce_pkg::ST_IDLE;
            seg_idx_reg   <= '0;
            pos_seg_reg   <= '0;
            tot_pos_reg   <= '0;
            from_reg      <= '0;
            res_v_reg     <= 1'b0;
            total_len_reg <= 17'd16384;
            start_lvl_reg <= '0;
            seg_cnt_reg   <= CW'(1);
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                frac_reg[i] <= '0;
                tgt_reg[i]  <= '0;
                shp_reg[i]  <= 1'b0;
                par_reg[i]  <= '0;
            end
        end
        else
        begin
            st_reg      <= st_next;
            seg_idx_reg <= seg_idx_next;
            pos_seg_reg <= pos_seg_next;
            tot_pos_reg <= tot_pos_next;
            from_reg    <= from_next;
            res_v_reg   <= res_v_next;
            if (ld)
            begin
                frac_reg[ld_slot] <= pce_pkg::sat17(cmd_item.seg_fraction);
                tgt_reg[ld_slot]  <= pce_pkg::sat17(cmd_item.seg_target);
                shp_reg[ld_slot]  <= cmd_item.seg_shape;
                par_reg[ld_slot]  <= cmd_item.shape_a;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pce_pkg::CFG_TOTAL_LENGTH:
                        total_len_reg <= (cfg_data[16:0] == '0) ? 17'd1
                                         : pce_pkg::sat17(cfg_data[16:0]);
                    pce_pkg::CFG_START_LEVEL:
                        start_lvl_reg <= pce_pkg::sat17(cfg_data[16:0]);
                    pce_pkg::CFG_SEGMENT_COUNT:
                        if (cfg_data[3:0] == '0)
                            seg_cnt_reg <= CW'(1);
                        else if (32'(cfg_data[3:0]) > 32'(MAX_SEGMENTS))
                            seg_cnt_reg <= CW'(MAX_SEGMENTS);
                        else
                            seg_cnt_reg <= CW'(cfg_data[3:0]);
                    default:
                        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        it_reg     <= it_next;
        xq_reg     <= xq_next;
        acc_reg    <= acc_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        s_reg      <= s_next;
        clamp_reg  <= clamp_next;
        res_reg    <= res_next;
    end
endmodule

FILE: src/piecewise_curve_envelope.sv
// top level of the piecewise curve envelope generator
// instantiates pce_front and pce_back; uses pce_pkg
//
//  channel   handshake            payload
//  input     push / full          in_item  (pce_pkg::in_item_t)
//  result    pop / empty          out_item (pce_pkg::out_item_t)
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a load or restart is carried out straight from idle in the back part; a tick
// runs longer, set by the bit-serial divider (one pass for a cubic, three for a
// cissoid) and, for a cissoid, by the bit-serial root
// reset clears tables and position; no clearing pass
// a waiting result stalls only the next tick; loads queue in the front part
module piecewise_curve_envelope #(
    parameter int MAX_SEGMENTS = pce_pkg::MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = pce_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  pce_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output pce_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic              cmd_valid, cmd_take, res_valid;
    pce_pkg::in_item_t cmd_item;

    assign cfg_ready = 1'b1;
    assign empty     = !res_valid;

    pce_front #(.QDEPTH(2)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .cmd_take  (cmd_take)
    );

    pce_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .cmd_take  (cmd_take),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_item  (out_item),
        .res_take  (pop)
    );
endmodule

FILE: tb/tb_piecewise_curve_envelope.sv
// testbench for piecewise_curve_envelope: drives segment loads, ticks and restarts,
// predicts each sample level and flag set in a scoreboard class; depends on pce_pkg
module tb_piecewise_curve_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    class envelope_scoreboard;
        logic [16:0] frac_tab[pce_pkg::MAX_SEGMENTS_DEF];
        logic [16:0] tgt_tab[pce_pkg::MAX_SEGMENTS_DEF];
        logic        shape_tab[pce_pkg::MAX_SEGMENTS_DEF];
        logic [23:0] a_tab[pce_pkg::MAX_SEGMENTS_DEF];
        int unsigned seg_idx, pos_seg, pos_total, from_lvl;
        int unsigned tot_len, start_lvl, seg_cnt;
        pce_pkg::out_item_t level_q[$];
        int unsigned errors;

        function new();
            for (int k = 0; k < pce_pkg::MAX_SEGMENTS_DEF; k++)
            begin
                frac_tab[k] = '0;
                tgt_tab[k] = '0;
                shape_tab[k] = 1'b0;
                a_tab[k] = '0;
            end
            tot_len = 16384;
            start_lvl = 0;
            seg_cnt = 1;
            errors = 0;
            restart_curve();
        endfunction

        function void restart_curve();
            seg_idx = 0;
            pos_seg = 0;
            pos_total = 0;
            from_lvl = start_lvl;
        endfunction

        function int unsigned clip_one(longint unsigned v);
            return (v > pce_pkg::Q16_ONE) ? pce_pkg::Q16_ONE : int'(v);
        endfunction

        function void write_register(pce_pkg::cfg_index_t idx, logic [31:0] data);
            int unsigned v;
            case (idx)
                pce_pkg::CFG_TOTAL_LENGTH:
                begin
                    v = data[16:0];
                    tot_len = (v == 0) ? 1 : clip_one(v);
                end
                pce_pkg::CFG_START_LEVEL: start_lvl = clip_one(data[16:0]);
                pce_pkg::CFG_SEGMENT_COUNT:
                begin
                    v = data[3:0];
                    if (v == 0) v = 1;
                    if (v > pce_pkg::MAX_SEGMENTS_DEF) v = pce_pkg::MAX_SEGMENTS_DEF;
                    seg_cnt = v;
                end
                default: return;
            endcase
            restart_curve();
        endfunction

        function int unsigned seg_length(int unsigned k);
            return int'((longint'(frac_tab[k]) * tot_len) >> 16);
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // cissoid sqrt(x^3/(2a-x)), saturating at one
        function longint unsigned cissoid_value(longint unsigned xq, longint unsigned a,
                                                output bit clamp);
            longint unsigned one, lim, twoa, d, p, q1, r1, q;
            one = 64'd1 << pce_pkg::FRAC_BITS_DEF;
            lim = one * one;
            twoa = a * 2;
            clamp = 1'b1;
            if (twoa <= xq) return one;
            d = twoa - xq;
            p = xq * xq;
            q1 = p / d;
            r1 = p % d;
            if (xq != 0 && q1 > lim / xq) return one;
            q = q1 * xq + (r1 * xq) / d;
            if (q > lim) return one;
            clamp = 1'b0;
            return int_root(q);
        endfunction

        function void note_input(pce_pkg::in_item_t it);
            pce_pkg::out_item_t exp;
            longint unsigned sum, xq, s, low, span, one;
            int unsigned len, tgt;
            bit clamp;
            one = 64'd1 << pce_pkg::FRAC_BITS_DEF;
            case (pce_pkg::action_t'(it.action))
                pce_pkg::ACT_LOAD:
                begin
                    frac_tab[it.slot] = 17'(clip_one(it.seg_fraction));
                    tgt_tab[it.slot] = 17'(clip_one(it.seg_target));
                    shape_tab[it.slot] = it.seg_shape;
                    a_tab[it.slot] = it.shape_a;
                    return;
                end
                pce_pkg::ACT_RESTART:
                begin
                    restart_curve();
                    return;
                end
                pce_pkg::ACT_TICK: ;
                default: return;
            endcase
            exp = '0;
            exp.segment_now = 4'(pce_pkg::MAX_SEGMENTS_DEF);
            sum = 0;
            for (int k = 0; k < seg_cnt; k++) sum += frac_tab[k];
            if (sum > pce_pkg::Q16_ONE)
            begin
                exp.finished = (pos_total >= tot_len);
                exp.overrun_error = 1'b1;
                level_q.push_back(exp);
                return;
            end
            if (pos_total >= tot_len)
            begin
                exp.finished = 1'b1;
                level_q.push_back(exp);
                return;
            end
            // zero-length or shortened segments are passed over here
            while (seg_idx < seg_cnt && pos_seg >= seg_length(seg_idx))
            begin
                from_lvl = tgt_tab[seg_idx];
                seg_idx++;
                pos_seg = 0;
            end
            if (seg_idx < seg_cnt)
            begin
                len = seg_length(seg_idx);
                tgt = tgt_tab[seg_idx];
                xq = (longint'(pos_seg) << pce_pkg::FRAC_BITS_DEF) / len;
                clamp = 1'b0;
                if (shape_tab[seg_idx])
                    s = ((((xq * xq) >> pce_pkg::FRAC_BITS_DEF)) * xq)
                        >> pce_pkg::FRAC_BITS_DEF;
                else
                    s = cissoid_value(xq, a_tab[seg_idx], clamp);
                if (from_lvl > tgt)
                begin
                    s = one - s;
                    low = tgt;
                    span = from_lvl - tgt;
                end
                else
                begin
                    low = from_lvl;
                    span = tgt - from_lvl;
                end
                exp.level = 17'(low + ((s * span) >> pce_pkg::FRAC_BITS_DEF));
                exp.segment_now = 4'(seg_idx);
                exp.domain_clamp = clamp;
                pos_seg++;
                if (pos_seg >= len)
                begin
                    from_lvl = tgt;
                    seg_idx++;
                    pos_seg = 0;
                end
            end
            pos_total++;
            exp.finished = (pos_total >= tot_len);
            level_q.push_back(exp);
        endfunction

        function void check_result(pce_pkg::out_item_t got);
            pce_pkg::out_item_t exp;
            if (level_q.size() == 0)
            begin
                $display("%0t: unexpected item %h", $time, got);
                errors++;
                return;
            end
            exp = level_q.pop_front();
            if (got.level !== exp.level)
            begin
                $display("%0t: level expected %0d actual %0d", $time, exp.level, got.level);
                errors++;
            end
            if (got.segment_now !== exp.segment_now)
            begin
                $display("%0t: segment_now expected %0d actual %0d", $time,
                         exp.segment_now, got.segment_now);
                errors++;
            end
            if (got.finished !== exp.finished)
            begin
                $display("%0t: finished expected %0b actual %0b", $time,
                         exp.finished, got.finished);
                errors++;
            end
            if (got.overrun_error !== exp.overrun_error)
            begin
                $display("%0t: overrun_error expected %0b actual %0b", $time,
                         exp.overrun_error, got.overrun_error);
                errors++;
            end
            if (got.domain_clamp !== exp.domain_clamp)
            begin
                $display("%0t: domain_clamp expected %0b actual %0b", $time,
                         exp.domain_clamp, got.domain_clamp);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    pce_pkg::in_item_t  in_item;
    logic               empty;
    logic               pop;
    pce_pkg::out_item_t out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    envelope_scoreboard sb;
    int unsigned tx_idle, rx_idle, sent, stall_count;

    piecewise_curve_envelope uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver side: check on accept, then choose next pop
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty) sb.check_result(out_item);
            pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(pce_pkg::in_item_t it);
        while ($urandom_range(99) < tx_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (full);
        sb.note_input(it);
        sent++;
    endtask

    // block must be idle before a register write
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.level_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(pce_pkg::cfg_index_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_register(idx, data);
        @(posedge clk);
    endtask

    function automatic pce_pkg::in_item_t load_item(int slot, int f, int t, bit s, int a);
        pce_pkg::in_item_t it;
        it = '0;
        it.action = pce_pkg::ACT_LOAD;
        it.slot = 3'(slot);
        it.seg_fraction = 17'(f);
        it.seg_target = 17'(t);
        it.seg_shape = s;
        it.shape_a = 24'(a);
        return it;
    endfunction

    function automatic pce_pkg::in_item_t ctrl_item(pce_pkg::action_t act);
        pce_pkg::in_item_t it;
        it = pce_pkg::in_item_t'({$urandom(), $urandom()});
        it.action = act;
        return it;
    endfunction

    function automatic int pick_a();
        if ($urandom_range(1))
            return $urandom_range(16384, 262144);
        return $urandom() & 32'hFFFFFF;
    endfunction

    task automatic run_curve();
        int cnt, tl, rem, f, ticks;
        drain();
        cnt = $urandom_range(1, pce_pkg::MAX_SEGMENTS_DEF);
        case ($urandom_range(11))
            0: tl = 65536;
            1: tl = $urandom_range(65537, 131071);
            2: tl = 1;
            default: tl = $urandom_range(2, 40);
        endcase
        write_cfg(pce_pkg::CFG_TOTAL_LENGTH, 32'(tl));
        write_cfg(pce_pkg::CFG_SEGMENT_COUNT, ($urandom_range(7) == 0) ? $urandom() : 32'(cnt));
        if ($urandom_range(3) == 0)
            write_cfg(pce_pkg::CFG_START_LEVEL,
                      ($urandom_range(1)) ? $urandom() : 32'(pce_pkg::Q16_ONE));
        cnt = sb.seg_cnt;
        rem = pce_pkg::Q16_ONE;
        for (int k = 0; k < cnt; k++)
        begin
            if ($urandom_range(9) == 0)
                f = $urandom_range(0, 131071);
            else if (k == cnt - 1)
                f = rem;
            else
                f = $urandom_range(0, rem);
            rem = (f > rem) ? 0 : rem - f;
            send_item(load_item(k, f, ($urandom_range(9) == 0) ? $urandom_range(0, 131071)
                                : $urandom_range(0, pce_pkg::Q16_ONE), $urandom_range(1),
                                pick_a()));
        end
        ticks = (sb.tot_len > 40) ? $urandom_range(5, 30) : sb.tot_len + $urandom_range(0, 3);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(pce_pkg::in_item_t'({$urandom(), $urandom()}));
            send_item(ctrl_item(pce_pkg::ACT_TICK));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = pce_pkg::CFG_TOTAL_LENGTH;
        cfg_data = '0;
        tx_idle = 0;
        rx_idle = 0;
        sent = 0;
        stall_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturated loads, both shapes, rising and falling
        write_cfg(pce_pkg::CFG_TOTAL_LENGTH, 32'd6);
        write_cfg(pce_pkg::CFG_SEGMENT_COUNT, 32'd3);
        write_cfg(pce_pkg::CFG_START_LEVEL, 32'h1FFFF);
        write_cfg(pce_pkg::CFG_UNUSED, 32'hFFFFFFFF);
        send_item(load_item(0, 21845, 0, 1'b1, 0));
        send_item(load_item(1, 0, 40000, 1'b0, 65536));
        send_item(load_item(2, 43691, 131071, 1'b0, 16777215));
        for (int i = 0; i < 8; i++) send_item(ctrl_item(pce_pkg::ACT_TICK));
        send_item(ctrl_item(pce_pkg::ACT_RESTART));
        send_item(ctrl_item(pce_pkg::ACT_NONE));
        // cissoid outside its domain and above one
        send_item(load_item(2, 43691, 65536, 1'b0, 0));
        send_item(load_item(0, 21845, 0, 1'b0, 20000));
        for (int i = 0; i < 4; i++) send_item(ctrl_item(pce_pkg::ACT_TICK));
        // fractions sum above one
        send_item(load_item(1, 131071, 0, 1'b1, 1));
        send_item(ctrl_item(pce_pkg::ACT_TICK));
        send_item(ctrl_item(pce_pkg::ACT_TICK));
        drain();
        write_cfg(pce_pkg::CFG_TOTAL_LENGTH, 32'd0);
        write_cfg(pce_pkg::CFG_SEGMENT_COUNT, 32'd0);
        write_cfg(pce_pkg::CFG_START_LEVEL, 32'd0);
        send_item(load_item(0, 65536, 65536, 1'b1, 1));
        send_item(ctrl_item(pce_pkg::ACT_TICK));
        send_item(ctrl_item(pce_pkg::ACT_TICK));

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 29 : (ph == 1) ? 66 : 0;
            rx_idle = (ph == 0) ? 66 : (ph == 1) ? 29 : 0;
            while (sent < 25 + (ph + 1) * 510) run_curve();
        end

        push <= 1'b0;
        @(posedge clk);
        while (sb.level_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
